>>> rtl/fcts_pkg.sv
// ----------------------------------------------------------------------------
// fcts_pkg
// Shared types and constants of the four-channel tone synthesiser.
// ----------------------------------------------------------------------------
`default_nettype none

package fcts_pkg;

    // Field widths
    localparam int RATE_W   = 17;
    localparam int PERIOD_W = 11;
    localparam int VOL_W    = 4;
    localparam int DUTY_W   = 2;
    localparam int PHASE_W  = 32;
    localparam int NOISE_W  = 15;
    localparam int SAMPLE_W = 16;

    // Channel numbers
    localparam logic [1:0] CH_SQ0   = 2'd0;
    localparam logic [1:0] CH_SQ1   = 2'd1;
    localparam logic [1:0] CH_WAVE  = 2'd2;
    localparam logic [1:0] CH_NOISE = 2'd3;

    // Register indexes of a write item
    localparam logic [2:0] REG_DUTY   = 3'd1;
    localparam logic [2:0] REG_VOLUME = 3'd2;
    localparam logic [2:0] REG_LOW    = 3'd3;
    localparam logic [2:0] REG_HIGH   = 3'd4;

    // Item kinds carried on the input tuser bit
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Phase step division: the numerator is base << 24, at most 2^41
    localparam int NUM_W     = 42;
    localparam int REM_W     = 28;
    localparam int DIV_CNT_W = 6;

    // Mixing constants
    localparam logic [8:0]           AMP_STEP    = 9'd400;
    localparam logic signed [15:0]   WAVE_HIGH   = 16'sd1400;
    localparam logic signed [15:0]   WAVE_LOW    = -16'sd1600;
    localparam logic signed [15:0]   MIX_LIMIT   = 16'sd28000;
    localparam logic [NOISE_W-1:0]   NOISE_SEED  = 15'h7FFF;
    localparam logic [PHASE_W-1:0]   PHASE_ONE   = 32'h0100_0000;
    localparam logic [PHASE_W-1:0]   STEP_SAT    = 32'hFFFF_FFFF;
    localparam logic [RATE_W-1:0]    RATE_RESET  = 17'd44100;
    localparam logic [PERIOD_W:0]    PERIOD_SPAN = 12'd2048;

    // One entry of the channel state memory
    typedef struct packed {
        logic                ch_on;
        logic [PHASE_W-1:0]  accum;
        logic [PHASE_W-1:0]  step;
        logic [VOL_W-1:0]    volume;
        logic [DUTY_W-1:0]   duty;
        logic [PERIOD_W-1:0] period;
    } entry_t;

    // Number of high steps out of eight for each duty setting
    function automatic logic [3:0] duty_limit(input logic [DUTY_W-1:0] sel);
        logic [3:0] lim;
        case (sel)
            2'd0:    lim = 4'd1;
            2'd1:    lim = 4'd2;
            2'd2:    lim = 4'd4;
            2'd3:    lim = 4'd6;
            default: lim = 4'd1;
        endcase
        return lim;
    endfunction

endpackage

`default_nettype wire

>>> rtl/fcts_step_div.sv
// ----------------------------------------------------------------------------
// fcts_step_div
// Derives a phase step as (base << 24) / (rate * (2048 - period)),
// one quotient bit per cycle, saturating to 32 bits; a zero divisor gives zero.
// ----------------------------------------------------------------------------
`default_nettype none

module fcts_step_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [fcts_pkg::RATE_W-1:0]   rate,
    input  wire logic [fcts_pkg::PERIOD_W-1:0] period,
    input  wire logic                          wave,
    output logic                               done,
    output logic [fcts_pkg::PHASE_W-1:0]       step
);
    import fcts_pkg::*;

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_MUL  = 3'b010,
        D_DIV  = 3'b100
    } dstate_t;

    dstate_t              state_reg, state_next;
    logic [RATE_W-1:0]    rate_reg;
    logic [PERIOD_W:0]    span_reg;
    logic                 wave_reg;
    logic [REM_W-1:0]     den_reg;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]     num_reg;
    logic [PHASE_W-1:0]   quo_reg, quo_next;
    logic                 sat_reg, sat_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic [PHASE_W-1:0]   step_reg;
    logic [REM_W:0]       trial;
    logic [REM_W:0]       diff;
    logic                 qbit;
    logic                 last;
    logic [RATE_W+PERIOD_W:0] product;

    // One restoring division step on the partial remainder
    always_comb
    begin
        trial    = {rem_reg, num_reg[NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        qbit     = (trial >= {1'b0, den_reg});
        rem_next = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
        quo_next = {quo_reg[PHASE_W-2:0], qbit};
        sat_next = sat_reg | quo_reg[PHASE_W-1];
        last     = (cnt_reg == DIV_CNT_W'(NUM_W - 1));
        product  = rate_reg * span_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE:  if (start) state_next = D_MUL;
            D_MUL:   state_next = D_DIV;
            D_DIV:   if (last) state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == D_DIV) && last;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                rate_reg <= rate;
                span_reg <= PERIOD_SPAN - {1'b0, period};
                wave_reg <= wave;
            end
            D_MUL:
            begin
                den_reg <= product[REM_W-1:0];
                rem_reg <= '0;
                quo_reg <= '0;
                sat_reg <= 1'b0;
                cnt_reg <= '0;
                num_reg <= wave_reg ? (NUM_W'(1) << (NUM_W - 2))
                                    : (NUM_W'(1) << (NUM_W - 1));
            end
            D_DIV:
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                sat_reg <= sat_next;
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (last)
                begin
                    if (den_reg == '0)
                        step_reg <= '0;
                    else if (sat_next)
                        step_reg <= STEP_SAT;
                    else
                        step_reg <= quo_next;
                end
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign step = step_reg;

endmodule

`default_nettype wire

>>> rtl/four_channel_tone_synth_unit.sv
// ----------------------------------------------------------------------------
// four_channel_tone_synth_unit
// Four-channel tone synthesiser: two squares, a fixed wave and a noise voice.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the s_axis channel. tuser = 0 marks a register write to
//   the channel in tdata; tuser = 1 asks for one mixed sample, which leaves
//   on the m_axis channel as a signed 16-bit value. The cfg channel writes
//   the sample rate used by triggers and is always ready; write it only
//   while the block is idle.
//   Channel state lives in a four-entry memory with a registered read. A
//   plain write reads, modifies and writes back its entry. A trigger adds a
//   multiply step and a bit-serial divider. A sample is one read, four
//   read-modify-write steps (one per channel) and a load into the output
//   register.
//   The output register lets the next item be taken while a sample waits;
//   if the receiver stalls, the following sample is held in the last step
//   until the output register frees. Reset clears all channel state through
//   per-entry valid bits, seeds the noise register and sets the rate to
//   44100.
// ----------------------------------------------------------------------------
`default_nettype none

module four_channel_tone_synth_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [1:0] channel, [4:2] reg_index,
                                            // [12:5] write_value, [15:13] zero
    input  wire logic [0:0]  s_axis_tuser,  // [0] req_type
    // Output samples
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // [15:0] sample (signed)
    // Sample rate register
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [16:0] cfg_data
);
    import fcts_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_DIV  = 5'b00100,
        S_TICK = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [RATE_W-1:0]      rate_reg;
    logic [NOISE_W-1:0]     noise_reg;
    logic [NOISE_W-1:0]     noise_next;
    logic [1:0]             ch_reg;
    logic [2:0]             regi_reg;
    logic [7:0]             val_reg;
    logic signed [SAMPLE_W-1:0] mix_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_W-1:0]    out_data_reg;
    entry_t                 hold_reg;

    // State memory
    entry_t                 mem [4];
    logic [3:0]             valid_reg;
    entry_t                 rd_data_reg;
    logic                   rd_valid_reg;
    logic [1:0]             rd_addr;
    logic                   wr_en;
    logic [1:0]             wr_addr;
    entry_t                 wr_data;
    entry_t                 rd_entry;

    // Divider
    logic                   div_start;
    logic                   div_done;
    logic [PHASE_W-1:0]     div_step;

    logic                   in_xfer;
    logic                   out_xfer;
    logic                   out_free;
    logic                   trigger;
    entry_t                 wmod;
    entry_t                 tupd;
    logic [PHASE_W-1:0]     sum32;
    logic [12:0]            amp;
    logic signed [SAMPLE_W-1:0] contrib;
    logic signed [SAMPLE_W-1:0] mix_sum;
    logic signed [SAMPLE_W-1:0] clamped;
    logic                   noise_fb;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Memory entries never written read as the reset value
    assign rd_entry = rd_valid_reg ? rd_data_reg : entry_t'('0);

    // Register write: modified entry
    always_comb
    begin
        wmod    = rd_entry;
        trigger = 1'b0;
        case (regi_reg)
            REG_DUTY:
            begin
                if (ch_reg == CH_SQ0 || ch_reg == CH_SQ1)
                    wmod.duty = val_reg[7:6];
            end
            REG_VOLUME:
            begin
                wmod.volume = val_reg[7:4];
                if (val_reg[7:4] == '0 && ch_reg != CH_WAVE)
                    wmod.ch_on = 1'b0;
            end
            REG_LOW:
            begin
                wmod.period[7:0] = val_reg;
            end
            REG_HIGH:
            begin
                wmod.period[PERIOD_W-1:8] = val_reg[2:0];
                if (val_reg[7])
                begin
                    trigger     = 1'b1;
                    wmod.ch_on  = 1'b1;
                    wmod.accum  = '0;
                end
            end
            default:
            begin
                wmod = rd_entry;
            end
        endcase
    end

    // Sample: update of one channel and its share of the mix
    always_comb
    begin
        tupd       = rd_entry;
        noise_next = noise_reg;
        contrib    = '0;
        sum32      = rd_entry.accum + rd_entry.step;
        amp        = {9'd0, rd_entry.volume} * {4'd0, AMP_STEP};
        noise_fb   = noise_reg[0] ^ noise_reg[1];
        case (ch_reg)
            CH_SQ0, CH_SQ1:
            begin
                if (rd_entry.ch_on)
                begin
                    if ({1'b0, rd_entry.accum[23:21]} < duty_limit(rd_entry.duty))
                        contrib = signed'(SAMPLE_W'(amp));
                    else
                        contrib = -signed'(SAMPLE_W'(amp));
                    tupd.accum = {8'h00, sum32[23:0]};
                end
            end
            CH_WAVE:
            begin
                if (rd_entry.ch_on)
                begin
                    tupd.accum = {8'h00, sum32[23:0]};
                    if (rd_entry.volume != '0)
                        contrib = sum32[23] ? WAVE_LOW : WAVE_HIGH;
                end
            end
            CH_NOISE:
            begin
                if (rd_entry.ch_on)
                begin
                    tupd.accum = sum32;
                    if (sum32[31:24] != '0)
                    begin
                        tupd.accum = sum32 - PHASE_ONE;
                        noise_next = {noise_fb, noise_reg[NOISE_W-1:1]};
                    end
                    contrib = noise_next[0] ? -signed'(SAMPLE_W'(amp))
                                            : signed'(SAMPLE_W'(amp));
                end
            end
            default:
            begin
                tupd = rd_entry;
            end
        endcase
        mix_sum = mix_reg + contrib;
        if (mix_reg > MIX_LIMIT)
            clamped = MIX_LIMIT;
        else if (mix_reg < -MIX_LIMIT)
            clamped = -MIX_LIMIT;
        else
            clamped = mix_reg;
    end

    // Memory access and sequencing
    always_comb
    begin
        state_next = state_reg;
        rd_addr    = ch_reg;
        wr_en      = 1'b0;
        wr_addr    = ch_reg;
        wr_data    = wmod;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                rd_addr = (s_axis_tuser[0] == KIND_TICK) ? CH_SQ0 : s_axis_tdata[1:0];
                if (in_xfer)
                    state_next = (s_axis_tuser[0] == KIND_TICK) ? S_TICK : S_RD;
            end
            S_RD:
            begin
                if (trigger)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                wr_data      = hold_reg;
                wr_data.step = div_step;
                if (div_done)
                begin
                    wr_en      = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TICK:
            begin
                rd_addr = ch_reg + 2'd1;
                wr_en   = 1'b1;
                wr_data = tupd;
                if (ch_reg == CH_NOISE)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory array with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rate_reg      <= RATE_RESET;
            noise_reg     <= NOISE_SEED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                rate_reg <= cfg_data;
            if (state_reg == S_RD && trigger && ch_reg == CH_NOISE)
                noise_reg <= NOISE_SEED;
            else if (state_reg == S_TICK)
                noise_reg <= noise_next;
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_xfer)
                out_valid_reg <= 1'b0;
        end
    end

    // Item fields, mix accumulator and output data
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ch_reg   <= (s_axis_tuser[0] == KIND_TICK) ? CH_SQ0 : s_axis_tdata[1:0];
            regi_reg <= s_axis_tdata[4:2];
            val_reg  <= s_axis_tdata[12:5];
            mix_reg  <= '0;
        end
        else if (state_reg == S_TICK)
        begin
            ch_reg  <= ch_reg + 2'd1;
            mix_reg <= mix_sum;
        end
        if (state_reg == S_RD)
            hold_reg <= wmod;
        if (state_reg == S_OUT && out_free)
            out_data_reg <= clamped;
    end

    fcts_step_div u_step_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .rate   (rate_reg),
        .period (wmod.period),
        .wave   (ch_reg == CH_WAVE),
        .done   (div_done),
        .step   (div_step)
    );

endmodule

`default_nettype wire

>>> dv/tb_four_channel_tone_synth_unit.sv
// ----------------------------------------------------------------------------
// tb_four_channel_tone_synth_unit
// Self-checking bench for the four-channel tone synthesiser.
// ----------------------------------------------------------------------------
// Register writes and sample requests are streamed into the block with random
// gaps, while the sample output is drained with random stalls and one long
// hold-off. A behavioural copy of the voices (squares, wave, noise register
// and the trigger-time phase step division) predicts every sample, and each
// sample transfer is compared against the oldest prediction. The sample rate
// is reprogrammed between phases, including the range limits, zero and a
// value low enough to saturate the phase step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_four_channel_tone_synth_unit;

    import fcts_pkg::*;

    // Unused register indexes, which the block must ignore
    localparam logic [2:0]  REG_NONE     = 3'd0;
    localparam logic [2:0]  REG_SPARE_LO = 3'd5;

    localparam logic [63:0] SQUARE_BASE_HZ = 64'd131072;
    localparam logic [63:0] WAVE_BASE_HZ   = 64'd65536;
    localparam logic [31:0] PHASE_MASK     = 32'h00FF_FFFF;
    // High steps out of eight per duty setting, four bits each
    localparam logic [15:0] HIGH_STEPS     = {4'd6, 4'd4, 4'd2, 4'd1};
    localparam int          DRAIN_CYCLES   = 64;
    localparam int          RANDOM_PHASE   = 120;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [1:0] channel, [4:2] reg_index, [12:5] write_value
    logic [0:0]  s_axis_tuser;   // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] sample (signed)
    logic        cfg_valid;
    logic        cfg_ready;
    logic [16:0] cfg_data;

    // Behavioural copy of the synthesiser state
    logic [RATE_W-1:0]   rate_hz;
    logic                v_on     [4];
    logic [31:0]         v_accum  [4];
    logic [31:0]         v_step   [4];
    logic [3:0]          v_vol    [4];
    logic [10:0]         v_period [4];
    logic [1:0]          duty_sel [2];
    logic [NOISE_W-1:0]  lfsr;

    logic [15:0] pending_samples [$];

    // Idling controls of the sender and the sample sink
    bit src_gaps_on;
    bit sink_stalls_on;
    int hold_left;
    int stall_left;

    int items_sent;
    int writes_sent;
    int ticks_sent;
    int triggers_seen;
    int samples_checked;
    int error_count;

    four_channel_tone_synth_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Voice prediction
    // ------------------------------------------------------------------------

    // Returns the state to its power-on values.
    task automatic clear_voices();
        int c;
        rate_hz = RATE_RESET;
        for (c = 0; c < 4; c++)
        begin
            v_on[c]     = 1'b0;
            v_accum[c]  = '0;
            v_step[c]   = '0;
            v_vol[c]    = '0;
            v_period[c] = '0;
        end
        duty_sel[0] = '0;
        duty_sel[1] = '0;
        lfsr        = NOISE_SEED;
    endtask

    // Phase step with a 24-bit fraction: base * 2^24 / (rate * (2048 - period)).
    function automatic logic [31:0] step_for_period(input logic [10:0] period,
                                                    input bit is_wave);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quot;
        num = (is_wave ? WAVE_BASE_HZ : SQUARE_BASE_HZ) << 24;
        den = 64'(rate_hz) * (64'(PERIOD_SPAN) - 64'(period));
        if (den == 0)
            return '0;
        quot = num / den;
        if (quot > 64'hFFFF_FFFF)
            return STEP_SAT;
        return quot[31:0];
    endfunction

    // Effect of one register write on the voice state.
    function automatic void apply_write(input logic [1:0] ch, input logic [2:0] idx,
                                        input logic [7:0] val);
        case (idx)
            REG_DUTY:
            begin
                if (ch == CH_SQ0 || ch == CH_SQ1)
                    duty_sel[ch[0]] = val[7:6];
            end
            REG_VOLUME:
            begin
                v_vol[ch] = val[7:4];
                if (val[7:4] == 4'd0 && ch != CH_WAVE)
                    v_on[ch] = 1'b0;
            end
            REG_LOW:
            begin
                v_period[ch] = {v_period[ch][10:8], val};
            end
            REG_HIGH:
            begin
                v_period[ch] = {val[2:0], v_period[ch][7:0]};
                if (val[7])
                begin
                    triggers_seen++;
                    v_on[ch]    = 1'b1;
                    v_accum[ch] = '0;
                    v_step[ch]  = step_for_period(v_period[ch], ch == CH_WAVE);
                    if (ch == CH_NOISE)
                        lfsr = NOISE_SEED;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Mixes all voices into one clamped sample and advances their phases.
    function automatic logic [15:0] mix_next_sample();
        int         mix;
        int         amp;
        int         c;
        logic [2:0] pos;
        logic [4:0] slot;
        logic       fb;
        mix = 0;

        // Square voices read their position before stepping.
        for (c = 0; c < 2; c++)
        begin
            if (v_on[c])
            begin
                pos = v_accum[c][23:21];
                amp = int'(v_vol[c]) * int'(AMP_STEP);
                if ({1'b0, pos} < HIGH_STEPS[{duty_sel[c], 2'b00} +: 4])
                    mix += amp;
                else
                    mix -= amp;
                v_accum[c] = (v_accum[c] + v_step[c]) & PHASE_MASK;
            end
        end

        // The wave voice steps first; half of its pattern is high.
        if (v_on[CH_WAVE])
        begin
            v_accum[CH_WAVE] = (v_accum[CH_WAVE] + v_step[CH_WAVE]) & PHASE_MASK;
            slot = v_accum[CH_WAVE][23:19];
            if (v_vol[CH_WAVE] != 4'd0)
                mix += (slot < 5'd16) ? int'(WAVE_HIGH) : int'(WAVE_LOW);
        end

        // Noise phase wraps at 32 bits and shifts the register once at most.
        if (v_on[CH_NOISE])
        begin
            amp = int'(v_vol[CH_NOISE]) * int'(AMP_STEP);
            v_accum[CH_NOISE] = v_accum[CH_NOISE] + v_step[CH_NOISE];
            if (v_accum[CH_NOISE] >= PHASE_ONE)
            begin
                v_accum[CH_NOISE] = v_accum[CH_NOISE] - PHASE_ONE;
                fb   = lfsr[0] ^ lfsr[1];
                lfsr = {fb, lfsr[NOISE_W-1:1]};
            end
            if (lfsr[0])
                mix -= amp;
            else
                mix += amp;
        end

        if (mix > int'(MIX_LIMIT))
            mix = int'(MIX_LIMIT);
        if (mix < -int'(MIX_LIMIT))
            mix = -int'(MIX_LIMIT);
        return 16'(mix);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly no gap, sometimes a short one and now and then a long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%s", msg);
    endtask

    // Offers one item and updates the prediction on its transfer.
    task automatic send_item(input logic kind, input logic [1:0] ch,
                             input logic [2:0] idx, input logic [7:0] val);
        int gap;
        gap = src_gaps_on ? draw_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b000, val, idx, ch};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (kind == KIND_TICK)
        begin
            ticks_sent++;
            pending_samples.push_back(mix_next_sample());
        end
        else
        begin
            writes_sent++;
            apply_write(ch, idx, val);
        end
    endtask

    task automatic write_reg(input logic [1:0] ch, input logic [2:0] idx,
                             input logic [7:0] val);
        send_item(KIND_WRITE, ch, idx, val);
    endtask

    // A sample request; the data bits are don't-care and are randomised.
    task automatic tick();
        send_item(KIND_TICK, 2'($urandom), 3'($urandom), 8'($urandom));
    endtask

    task automatic program_voice(input logic [1:0] ch, input logic [7:0] duty,
                                 input logic [7:0] vol, input logic [7:0] lo,
                                 input logic [7:0] hi);
        write_reg(ch, REG_DUTY, duty);
        write_reg(ch, REG_VOLUME, vol);
        write_reg(ch, REG_LOW, lo);
        write_reg(ch, REG_HIGH, hi);
    endtask

    // Waits until every sample has arrived and a trigger may have finished.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_rate(input logic [RATE_W-1:0] r);
        wait_idle();
        cfg_data  <= r;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        rate_hz = r;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Silent output after reset; unused indexes and duty on wave or noise
    // leave everything unchanged.
    task automatic test_idle_channels();
        logic [2:0] idx;
        tick();
        write_reg(CH_SQ0, REG_NONE, 8'hFF);
        for (idx = REG_SPARE_LO; idx != REG_NONE; idx++)
            write_reg(2'($urandom), idx, 8'($urandom));
        write_reg(CH_WAVE, REG_DUTY, 8'hC0);
        write_reg(CH_NOISE, REG_DUTY, 8'h40);
        tick();
    endtask

    // Every register and both period extremes, then muting and disabling.
    task automatic test_voice_setup();
        program_voice(CH_SQ0, 8'hC0, 8'hF0, 8'h00, 8'h80);
        program_voice(CH_SQ1, 8'h40, 8'h8F, 8'hFF, 8'h87);
        program_voice(CH_WAVE, 8'h80, 8'h10, 8'h55, 8'h82);
        program_voice(CH_NOISE, 8'h00, 8'hF0, 8'hFF, 8'h87);
        repeat (4) tick();
        // A silent wave voice stays enabled; a zero volume stops a square.
        write_reg(CH_WAVE, REG_VOLUME, 8'h0F);
        write_reg(CH_SQ1, REG_VOLUME, 8'h0F);
        repeat (2) tick();
    endtask

    task automatic retrigger_at_rate(input logic [RATE_W-1:0] r, input int n_ticks);
        set_rate(r);
        write_reg(CH_SQ0, REG_HIGH, 8'h87);
        write_reg(CH_WAVE, REG_HIGH, 8'h87);
        write_reg(CH_NOISE, REG_HIGH, 8'h87);
        repeat (n_ticks) tick();
    endtask

    // Range limits of the rate, a zero rate and a rate so low the step
    // saturates. The slowest legal rate lets the noise phase wrap.
    task automatic test_rate_extremes();
        write_reg(CH_WAVE, REG_VOLUME, 8'hF0);
        retrigger_at_rate(17'd8000, 18);
        retrigger_at_rate(17'd96000, 3);
        retrigger_at_rate(17'd0, 3);
        retrigger_at_rate(17'd1, 3);
    endtask

    // Mostly complete voice set-ups followed by samples, mixed with lone
    // samples and arbitrary writes.
    task automatic run_random_phase(input int n_items);
        int         done;
        int         r;
        int         n_ticks;
        logic [1:0] ch;
        logic [2:0] idx;
        logic [7:0] vol;
        logic [7:0] lo;
        done = 0;
        while (done < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                ch  = 2'($urandom);
                vol = 8'($urandom);
                if ($urandom_range(0, 99) < 85 && vol[7:4] == 4'd0)
                    vol[7:4] = 4'($urandom_range(1, 15));
                r  = $urandom_range(0, 9);
                lo = (r < 2) ? 8'hFF : (r < 3) ? 8'h00 : 8'($urandom);
                program_voice(ch, 8'($urandom), vol, lo, {1'b1, 7'($urandom)});
                n_ticks = $urandom_range(1, 8);
                repeat (n_ticks) tick();
                done += 4 + n_ticks;
            end
            else if (r < 80)
            begin
                tick();
                done++;
            end
            else
            begin
                idx = 3'($urandom);
                write_reg(2'($urandom), idx, 8'($urandom));
                if (idx >= REG_DUTY && idx <= REG_HIGH)
                    done++;
            end
        end
    endtask

    task automatic test_random_traffic();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        set_rate(17'($urandom_range(8000, 96000)));
        run_random_phase(RANDOM_PHASE);

        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        set_rate(17'd8000);
        run_random_phase(RANDOM_PHASE);

        set_rate(17'd96000);
        run_random_phase(RANDOM_PHASE);

        sink_stalls_on = 1'b0;
        set_rate(RATE_RESET);
        run_random_phase(RANDOM_PHASE);
        sink_stalls_on = 1'b1;
    endtask

    // The sink holds off for a long stretch while requests keep coming, so
    // the block must fill up and stall its input.
    task automatic test_output_backpressure();
        src_gaps_on = 1'b0;
        hold_left   = 400;
        repeat (24) tick();
        src_gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sample sink: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : sink_drive
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (sink_stalls_on && $urandom_range(0, 3) == 0)
                    stall_left = draw_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sample checker: each output transfer against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [15:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_samples.size() == 0)
            begin
                report_error($sformatf("%0t: unexpected sample %0d", $realtime,
                                       $signed(m_axis_tdata)));
            end
            else
            begin
                want = pending_samples.pop_front();
                samples_checked++;
                if (m_axis_tdata !== want)
                    report_error($sformatf("%0t: sample mismatch, expected %0d got %0d",
                                           $realtime, $signed(want),
                                           $signed(m_axis_tdata)));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : run_tests
        rst_n          <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= KIND_WRITE;
        cfg_valid      <= 1'b0;
        cfg_data       <= '0;
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        hold_left      = 0;
        stall_left     = 0;
        clear_voices();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_channels();
        test_voice_setup();
        test_rate_extremes();
        test_random_traffic();
        test_output_backpressure();
        wait_idle();

        $display("Sent %0d items: %0d register writes (%0d triggers) and %0d sample requests.",
                 items_sent, writes_sent, triggers_seen, ticks_sent);
        $display("Checked %0d samples over rates 0, 1, 8000, 44100, 96000 and one random rate.",
                 samples_checked);
        if (error_count == 0)
            $display("tb_four_channel_tone_synth_unit: PASS");
        else
            $display("tb_four_channel_tone_synth_unit: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin : watchdog
        #12_000_000;
        $display("Timed out with %0d samples outstanding.", pending_samples.size());
        $display("tb_four_channel_tone_synth_unit: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
